// ===== src/dcnt_pkg.sv =====
// Shared types, register indexes and codes for the down-counting timer.
// Depends on nothing; every other file in src imports it.
package dcnt_pkg;

  // Counter width; visible_count and max_skip stay 32 bits at any width.
  localparam int COUNTER_BITS = 32;
  localparam int CNT_W        = COUNTER_BITS;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [63:0] OUT_MAX = 64'h0000_0000_FFFF_FFFF;

  // Register indexes (paddr[3:2]).
  localparam logic [1:0] REG_TIMER_MODE    = 2'd0;
  localparam logic [1:0] REG_PAUSED        = 2'd1;
  localparam logic [1:0] REG_MIRROR_ENABLE = 2'd2;
  localparam logic [1:0] REG_START_VALUE   = 2'd3;

  // Counting modes.
  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_AUTO   = 2'd1;
  localparam logic [1:0] MODE_FREE   = 2'd2;
  localparam logic [1:0] MODE_EVENT  = 2'd3;

  // Operations.
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_EVENT   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_SKIP    = 2'd3;

  typedef struct packed {
    logic [1:0]  timer_mode;
    logic        paused;
    logic        mirror_enable;
    logic [31:0] start_value;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] skip_ticks;
  } in_item_t;

  typedef struct packed {
    logic [31:0] visible_count;
    logic        interrupt_pulse;
    logic [31:0] max_skip;
    logic        max_skip_unbounded;
    logic        skip_rejected;
  } out_item_t;

  function automatic logic [63:0] to_wide(input logic [CNT_W-1:0] c);
    return 64'(c);
  endfunction

  function automatic logic [CNT_W-1:0] to_cnt(input logic [63:0] v);
    return v[CNT_W-1:0];
  endfunction

endpackage

// ===== src/dsp_down_counter_timer_top.sv =====
// Top level of the down-counting timer: input register, core, result register.
// Depends on dcnt_pkg, dcnt_regs and dcnt_core.
//
//   channel   direction  handshake                  payload
//   item      in         item_valid / item_stall    in_item_t  (operation, skip_ticks)
//   result    out        result_valid / result_stall out_item_t (one per item)
//   config    in         psel, penable, pwrite      paddr, pwdata -> prdata, pready
//
// Each item passes through the input register, then through the core into the
// result register. A new item is taken every cycle while the result is not
// stalled; the counter update is one compare and subtract in the core, so
// back-to-back items see each other's counter without bubbles.
// rst is synchronous, active high: counter, mirror, registers and valids clear.
// A stalled result holds the input register; item_stall rises only then.
module dsp_down_counter_timer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  dcnt_pkg::in_item_t          item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output dcnt_pkg::out_item_t         result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dcnt_pkg::ADDR_W-1:0] paddr,
  input  logic [dcnt_pkg::DATA_W-1:0] pwdata,
  output logic [dcnt_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import dcnt_pkg::*;

  cfg_t      cfg;
  in_item_t  held_item;
  logic      held_valid;
  out_item_t core_result;
  logic      advance;
  logic      step;

  dcnt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The result register can take a new transaction unless it holds a stalled one.
  assign advance    = !(result_valid && result_stall);
  assign step       = held_valid && advance;
  // Hold the input register only while its item cannot move on.
  assign item_stall = held_valid && !advance;

  dcnt_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .cfg    (cfg),
    .item   (held_item),
    .result (core_result)
  );

  // Input register: load on every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      held_item <= item;
    end
  end

  // Result register: advance when not stalled, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= core_result;
    end
  end

`ifndef SYNTH
  a_held_kept: assert property (@(posedge clk) disable iff (rst)
    held_valid && !advance |=> held_valid && $stable(held_item))
    else $error("held item lost while result stalled");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    step |=> result_valid)
    else $error("core step did not produce a result");

  a_irq_not_rejected: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.interrupt_pulse && result.skip_rejected))
    else $error("interrupt and skip rejection in the same result");

  a_unbounded_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.max_skip_unbounded |-> result.max_skip == '0)
    else $error("unbounded max_skip carries a value");
`endif

endmodule

// ===== src/dcnt_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on dcnt_pkg for the register indexes and cfg_t.
module dcnt_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [dcnt_pkg::ADDR_W-1:0] paddr,
  input  logic [dcnt_pkg::DATA_W-1:0] pwdata,
  output logic [dcnt_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output dcnt_pkg::cfg_t            cfg
);
  import dcnt_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TIMER_MODE:    cfg.timer_mode    <= pwdata[1:0];
        REG_PAUSED:        cfg.paused        <= pwdata[0];
        REG_MIRROR_ENABLE: cfg.mirror_enable <= pwdata[0];
        REG_START_VALUE:   cfg.start_value   <= pwdata[31:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_TIMER_MODE:    prdata[1:0]  = cfg.timer_mode;
      REG_PAUSED:        prdata[0]    = cfg.paused;
      REG_MIRROR_ENABLE: prdata[0]    = cfg.mirror_enable;
      REG_START_VALUE:   prdata[31:0] = cfg.start_value;
    endcase
  end

endmodule

// ===== src/dcnt_core.sv =====
// Counter and mirror registers with the single-pass next-state logic.
// Depends on dcnt_pkg for codes, cfg_t, in_item_t and out_item_t.
module dcnt_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  dcnt_pkg::cfg_t       cfg,
  input  dcnt_pkg::in_item_t   item,
  output dcnt_pkg::out_item_t  result
);
  import dcnt_pkg::*;

  logic [CNT_W-1:0] count_now, count_now_next;
  logic [CNT_W-1:0] count_mirror, count_mirror_next;
  logic [CNT_W-1:0] start_cnt, cnt_dec, reload;
  logic [63:0]      ticks_w, ms_w, mirror_w;
  logic             run, wr, irq, rej, unbounded;

  assign start_cnt = to_cnt(64'(cfg.start_value));
  assign cnt_dec   = count_now - CNT_W'(1);
  assign ticks_w   = 64'(item.skip_ticks);
  assign run       = !cfg.paused && (cfg.timer_mode != MODE_EVENT);
  assign reload    = (cfg.timer_mode == MODE_AUTO) ? start_cnt : '1;

  always_comb begin
    count_now_next = count_now;
    wr  = 1'b0;
    irq = 1'b0;
    rej = 1'b0;
    unique case (item.operation)
      OP_TICK: begin
        if (run) begin
          if (count_now == '0) begin
            if (cfg.timer_mode == MODE_AUTO || cfg.timer_mode == MODE_FREE) begin
              count_now_next = reload;
              wr = 1'b1;
            end
          end else begin
            count_now_next = cnt_dec;
            wr  = 1'b1;
            irq = (cnt_dec == '0);
          end
        end
      end
      OP_EVENT: begin
        if (!cfg.paused && cfg.timer_mode == MODE_EVENT && count_now != '0) begin
          count_now_next = cnt_dec;
          wr  = 1'b1;
          irq = (cnt_dec == '0);
        end
      end
      OP_RESTART: begin
        if (cfg.timer_mode != MODE_FREE) begin
          count_now_next = start_cnt;
          wr = 1'b1;
        end
      end
      OP_SKIP: begin
        if (run && item.skip_ticks != '0) begin
          if (count_now == '0) begin
            // Zero counter in auto or free mode: first tick reloads, the rest count down.
            if (cfg.timer_mode == MODE_AUTO || cfg.timer_mode == MODE_FREE) begin
              if (ticks_w > to_wide(reload)) begin
                rej = 1'b1;
              end else begin
                count_now_next = to_cnt(to_wide(reload) - ticks_w + 64'd1);
                wr = 1'b1;
              end
            end
          end else if (to_wide(count_now) <= ticks_w) begin
            rej = 1'b1;
          end else begin
            count_now_next = to_cnt(to_wide(count_now) - ticks_w);
            wr = 1'b1;
          end
        end
      end
    endcase
  end

  assign count_mirror_next = (wr && cfg.mirror_enable) ? count_now_next : count_mirror;

  always_comb begin
    ms_w      = '0;
    unbounded = 1'b0;
    if (!run) begin
      unbounded = 1'b1;
    end else if (count_now_next == '0) begin
      if (cfg.timer_mode == MODE_AUTO || cfg.timer_mode == MODE_FREE) begin
        ms_w = to_wide(reload);
      end else begin
        unbounded = 1'b1;
      end
    end else begin
      ms_w = to_wide(count_now_next) - 64'd1;
    end
  end

  assign mirror_w = to_wide(count_mirror_next);

  always_comb begin
    result.visible_count      = mirror_w[31:0];
    result.interrupt_pulse    = irq;
    result.max_skip           = (ms_w > OUT_MAX) ? 32'hFFFF_FFFF : ms_w[31:0];
    result.max_skip_unbounded = unbounded;
    result.skip_rejected      = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_now    <= '0;
      count_mirror <= '0;
    end else if (step) begin
      count_now    <= count_now_next;
      count_mirror <= count_mirror_next;
    end
  end

endmodule
